// ===== hw/rtl/kmp_pkg.sv =====
package kmp_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_FAIL,
		ST_MATCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;        // input transfer this cycle
		logic pat_from_fail; // pattern read address and k from failure data
		logic f_sel_last;    // failure read at count-1 instead of k-1
		logic append_done;   // commit failure entry, grow pattern
		logic text_done;     // commit matched length, advance text
		logic match_done;    // load result, fall back, advance text
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic k_zero;
		logic mismatch;
		logic k_full;
		logic out_busy;
		logic matched_zero;
	} sts_t;

endpackage

// ===== hw/rtl/kmp_ram.sv =====
module kmp_ram import kmp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/kmp_ctrl.sv =====
module kmp_ctrl import kmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   append_q;
	logic   start;
	logic   fall;

	// accepted item needs the compare loop
	assign start = (op == OP_APPEND && !sts.count_zero && !sts.count_full) ||
	               (op == OP_TEXT && !sts.count_zero);
	assign fall  = !sts.k_zero && sts.mismatch;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			append_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				append_q <= (op == OP_APPEND);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && start) state_d = ST_CMP;
			end
			ST_CMP: begin
				if (fall) state_d = ST_FAIL;
				else if (append_q) state_d = ST_IDLE;
				else if (sts.k_full) state_d = ST_MATCH;
				else state_d = ST_IDLE;
			end
			ST_FAIL: state_d = ST_CMP;
			ST_MATCH: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.accept = in_valid;
			ST_CMP: begin
				if (!fall) begin
					if (append_q) cmd.append_done = 1'b1;
					else if (sts.k_full) cmd.f_sel_last = 1'b1;
					else cmd.text_done = 1'b1;
				end
			end
			ST_FAIL: cmd.pat_from_fail = 1'b1;
			ST_MATCH: begin
				cmd.f_sel_last = 1'b1;
				cmd.match_done = !sts.out_busy;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/kmp_datapath.sv =====
module kmp_datapath import kmp_pkg::*; #(
	parameter int PATTERN_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  op,
	input  logic [7:0]  byte_value,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [31:0] match_position
);

	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CW = $clog2(PATTERN_MAX + 1);

	logic [CW-1:0] count_q, build_q, matched_q, k_q;
	logic [31:0]   text_q;
	logic [7:0]    byte_q;
	logic          out_valid_q;
	logic [31:0]   pos_q;

	logic [7:0]    pat_rdata;
	logic [CW-1:0] f_rdata;
	logic [CW-1:0] k_src, pat_ra_full, f_ra_full, k_inc, count_m1, k_m1;
	logic          pat_we, f_we;
	logic [CW-1:0] f_wdata;

	assign k_src       = (op == OP_TEXT) ? matched_q : build_q;
	assign pat_ra_full = cmd.pat_from_fail ? f_rdata : (cmd.accept ? k_src : k_q);
	assign count_m1    = count_q - CW'(1);
	assign k_m1        = k_q - CW'(1);
	assign f_ra_full   = cmd.f_sel_last ? count_m1 : k_m1;
	assign k_inc       = k_q + CW'(pat_rdata == byte_q);

	assign sts.count_zero   = (count_q == '0);
	assign sts.count_full   = (count_q == CW'(PATTERN_MAX));
	assign sts.k_zero       = (k_q == '0);
	assign sts.mismatch     = (pat_rdata != byte_q);
	assign sts.k_full       = (k_inc == count_q);
	assign sts.out_busy     = out_valid_q && !out_ready;
	assign sts.matched_zero = (matched_q == '0);

	assign pat_we  = cmd.accept && op == OP_APPEND && !sts.count_full;
	// first pattern byte has an empty prefix
	assign f_we    = (cmd.accept && op == OP_APPEND && sts.count_zero) || cmd.append_done;
	assign f_wdata = cmd.append_done ? k_inc : '0;

	kmp_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pattern (
		.clk   (clk),
		.we    (pat_we),
		.waddr (count_q[AW-1:0]),
		.wdata (byte_value),
		.raddr (pat_ra_full[AW-1:0]),
		.rdata (pat_rdata)
	);

	kmp_ram #(.WIDTH(CW), .DEPTH(PATTERN_MAX)) u_failure (
		.clk   (clk),
		.we    (f_we),
		.waddr (count_q[AW-1:0]),
		.wdata (f_wdata),
		.raddr (f_ra_full[AW-1:0]),
		.rdata (f_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= byte_value;
			k_q    <= k_src;
		end else if (cmd.pat_from_fail) begin
			k_q <= f_rdata;
		end
		if (cmd.match_done) begin
			pos_q <= text_q - 32'(count_q) + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			build_q     <= '0;
			matched_q   <= '0;
			text_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// slot loads on a match, holds until its transfer
			out_valid_q <= cmd.match_done || (out_valid_q && !out_ready);
			if (cmd.accept) begin
				case (op)
					OP_CLEAR: begin
						count_q   <= '0;
						build_q   <= '0;
						matched_q <= '0;
						text_q    <= '0;
					end
					OP_APPEND: begin
						matched_q <= '0;
						text_q    <= '0;
						if (sts.count_zero) begin
							count_q <= CW'(1);
							build_q <= '0;
						end
					end
					OP_TEXT: begin
						if (sts.count_zero) text_q <= text_q + 32'd1;
					end
					default: ;
				endcase
			end
			if (cmd.append_done) begin
				build_q <= k_inc;
				count_q <= count_q + CW'(1);
			end
			if (cmd.text_done) begin
				matched_q <= k_inc;
				text_q    <= text_q + 32'd1;
			end
			if (cmd.match_done) begin
				matched_q <= f_rdata;
				text_q    <= text_q + 32'd1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign match_position = pos_q;

endmodule

// ===== hw/rtl/kmp_stream_matcher.sv =====
// Channel  Signals                                   Direction  Moves
// -------  ----------------------------------------  ---------  --------------------------
// in       in_valid, in_ready, op, byte_value        sink       one command per transfer
// out      out_valid, out_ready, match_position      source     one match start per transfer
//
// Steps: clear, nop, an append to an empty or a full pattern and text with an empty
//   pattern finish in idle. Any other text byte or append adds the compare state, plus
//   failure-link and compare again per failure link followed (failure RAM read, then pattern
//   RAM read, each registered); a full match adds the match state for the fallback read.
// Reset: arst_n clears pattern length, prefix/match state, text index and the output slot.
// Stalls: a held result does not block input; only a second match waits for the slot to free.
module kmp_stream_matcher import kmp_pkg::*; #(
	parameter int PATTERN_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] match_position
);

	// command/status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle / compare / failure-link / match
	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pattern and failure RAMs, counters, result register
	kmp_datapath #(.PATTERN_MAX(PATTERN_MAX)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.byte_value     (byte_value),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.match_position (match_position)
	);

	// a text byte against a stored pattern always goes through the compare loop
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_TEXT && !sts.count_zero |=> !in_ready)
		else $error("text transfer did not enter compare loop");

	// clear empties the pattern
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_CLEAR |=> sts.count_zero)
		else $error("clear left pattern non-empty");

	// any append drops match progress
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_APPEND |=> sts.matched_zero)
		else $error("append kept match state");

endmodule
